FILE: hdl/cumulative_matrix_product_assert.svh
`ifndef CUMULATIVE_MATRIX_PRODUCT_ASSERT_SVH
`define CUMULATIVE_MATRIX_PRODUCT_ASSERT_SVH

// Check that a condition in this cycle implies another in the same cycle
`define CMP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmp: same-cycle check failed");

// Check that a condition in this cycle implies another in the next cycle
`define CMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmp: next-cycle check failed");

`endif

FILE: hdl/cmp_pkg.sv
package cmp_pkg;

    localparam int ELEM_W   = 32;
    localparam int IDX_W    = 3;
    localparam int STEP_W   = 8;
    localparam int SIZE_W   = 4;
    localparam int CNT_W    = 7;
    localparam int OUT_W    = 48;
    localparam int ACC_W    = 2 * ELEM_W + 3;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_LOAD_RUN,
        CMD_LOAD_FAC,
        CMD_LOAD_FAC_LAST
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [CNT_W-1:0]         addr;
        logic [SIZE_W-1:0]        size;
        logic [ELEM_W-1:0]        value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPUTE,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

endpackage

FILE: hdl/cmp_front.sv
module cmp_front #(
    parameter int MAX_SIZE = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cmp_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic                       s_tuser,
    input  logic [cmp_pkg::ELEM_W-1:0] s_tdata,
    input  logic                       full,
    output logic                       push,
    output cmp_pkg::cmd_t              push_cmd
);

    logic [cmp_pkg::SIZE_W-1:0] size_reg;
    logic [cmp_pkg::CNT_W-1:0]  ctr_reg;
    logic [cmp_pkg::CNT_W-1:0]  ctr_next;
    logic                       lop_reg;
    logic [cmp_pkg::SIZE_W-1:0] n_eff;
    logic [cmp_pkg::CNT_W-1:0]  total;
    logic [cmp_pkg::CNT_W-1:0]  cnt;
    logic [cmp_pkg::CNT_W-1:0]  cnt_inc;
    logic                       at_end;

    // Clamp the size register into the legal range
    always_comb
    begin
        if (size_reg == '0)
            n_eff = cmp_pkg::SIZE_W'(1);
        else if (size_reg > cmp_pkg::SIZE_W'(MAX_SIZE))
            n_eff = cmp_pkg::SIZE_W'(MAX_SIZE);
        else
            n_eff = size_reg;
    end

    assign total = cmp_pkg::CNT_W'({3'b000, n_eff} * {3'b000, n_eff});

    // Classify the item and pick its element slot
    always_comb
    begin
        cnt = (s_tuser != lop_reg) ? '0 : ctr_reg;
        if (cnt >= total)
            cnt = '0;
        cnt_inc  = cnt + cmp_pkg::CNT_W'(1);
        at_end   = (cnt_inc >= total);
        ctr_next = at_end ? '0 : cnt_inc;
    end

    assign s_tready = !full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_cmd.addr  = cnt;
        push_cmd.size  = n_eff;
        push_cmd.value = s_tdata;
        if (!s_tuser)
            push_cmd.kind = cmp_pkg::CMD_LOAD_RUN;
        else if (at_end)
            push_cmd.kind = cmp_pkg::CMD_LOAD_FAC_LAST;
        else
            push_cmd.kind = cmp_pkg::CMD_LOAD_FAC;
    end

    // Track size, loading kind and element position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= cmp_pkg::SIZE_W'(8);
            ctr_reg  <= '0;
            lop_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
            ctr_reg  <= '0;
        end
        else if (push)
        begin
            lop_reg <= s_tuser;
            ctr_reg <= ctr_next;
        end
    end

endmodule

FILE: hdl/cmp_fifo.sv
module cmp_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmp_pkg::cmd_t push_cmd,
    input  logic          pop,
    output cmp_pkg::cmd_t pop_cmd,
    output logic          full,
    output logic          empty
);

    cmp_pkg::cmd_t entry_reg [cmp_pkg::FIFO_DEPTH];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'(cmp_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rptr_reg];

    // Hold command payloads
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_cmd;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

`include "cumulative_matrix_product_assert.svh"
    `CMP_ASSERT_SAME(a_no_push_full, push, !full)
    `CMP_ASSERT_SAME(a_no_pop_empty, pop, !empty)

endmodule

FILE: hdl/cmp_back.sv
module cmp_back #(
    parameter int MAX_SIZE      = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       empty,
    input  cmp_pkg::cmd_t              pop_cmd,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cmp_pkg::OUT_W-1:0]  m_tdata,
    output logic                       m_tlast
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_N = 1 << AW;
    localparam int CW    = cmp_pkg::CNT_W;
    localparam int IW    = cmp_pkg::IDX_W;
    localparam int EW    = cmp_pkg::ELEM_W;
    localparam int AC    = cmp_pkg::ACC_W;

    cmp_pkg::state_t state_reg;
    cmp_pkg::state_t state_next;

    // Storage
    logic [EW-1:0]   run_mem [MEM_N];
    logic [EW-1:0]   fac_mem [MEM_N];
    logic [EW-1:0]   new_mem [MEM_N];
    logic [MEM_N-1:0] run_valid_reg;

    // Sequencer state
    logic [cmp_pkg::SIZE_W-1:0] n_reg;
    logic [CW-1:0]              total_reg;
    logic [cmp_pkg::STEP_W-1:0] step_reg;
    logic [IW-1:0]              i_reg, j_reg, k_reg;
    logic [CW-1:0]              row_base_reg, rk_reg;
    logic                       issue_done_reg;
    logic [IW-1:0]              n_m1;

    // MAC pipeline
    logic                 p1_valid_reg, p1_first_reg, p1_last_reg;
    logic [CW-1:0]        p1_idx_reg;
    logic                 p2_valid_reg, p2_first_reg, p2_last_reg;
    logic [CW-1:0]        p2_idx_reg;
    logic                 p3_valid_reg, p3_last_reg;
    logic [CW-1:0]        p3_idx_reg;
    logic [EW-1:0]        fac_rd_reg, run_rd_reg;
    logic signed [2*EW-1:0] prod_reg;
    logic signed [2*EW-1:0] prod_sh;
    logic signed [AC-1:0] term;
    logic signed [AC-1:0] acc_reg;
    logic [EW-1:0]        sat_val;
    logic                 sat_ovf;
    logic                 final_wr;

    // Emit side
    logic [EW-1:0]        new_rd_reg;
    logic [CW-1:0]        e_reg;
    logic [IW-1:0]        oi_reg, oj_reg;
    logic                 out_valid_reg;
    logic [IW-1:0]        out_row_reg, out_col_reg;
    logic [EW-1:0]        out_val_reg;
    logic [cmp_pkg::STEP_W-1:0] out_step_reg;
    logic                 out_last_reg;
    logic                 emit_last;

    // Control strobes
    logic                 issue;
    logic                 fac_we;
    logic                 run_we;
    logic [AW-1:0]        run_wa;
    logic [EW-1:0]        run_wd;
    logic                 out_load;
    logic [CW-1:0]        fa, ra, ia;

    assign n_m1      = IW'(n_reg - cmp_pkg::SIZE_W'(1));
    assign fa        = row_base_reg + CW'(k_reg);
    assign ra        = rk_reg + CW'(j_reg);
    assign ia        = row_base_reg + CW'(j_reg);
    assign final_wr  = p3_valid_reg && p3_last_reg
                       && (p3_idx_reg == total_reg - CW'(1));
    assign emit_last = (e_reg == total_reg - CW'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cmp_pkg::ST_IDLE:
                if (pop && pop_cmd.kind == cmp_pkg::CMD_LOAD_FAC_LAST)
                    state_next = cmp_pkg::ST_COMPUTE;
            cmp_pkg::ST_COMPUTE:
                if (final_wr)
                    state_next = cmp_pkg::ST_EMIT_RD;
            cmp_pkg::ST_EMIT_RD:
                state_next = cmp_pkg::ST_EMIT_WR;
            cmp_pkg::ST_EMIT_WR:
                if (out_load)
                    state_next = emit_last ? cmp_pkg::ST_IDLE : cmp_pkg::ST_EMIT_RD;
            default:
                state_next = cmp_pkg::ST_IDLE;
        endcase
    end

    // Output strobes
    always_comb
    begin
        pop      = (state_reg == cmp_pkg::ST_IDLE) && !empty;
        issue    = (state_reg == cmp_pkg::ST_COMPUTE) && !issue_done_reg;
        out_load = (state_reg == cmp_pkg::ST_EMIT_WR) && (!out_valid_reg || m_tready);
        fac_we   = pop && (pop_cmd.kind != cmp_pkg::CMD_LOAD_RUN);
        run_we   = (pop && pop_cmd.kind == cmp_pkg::CMD_LOAD_RUN) || out_load;
        run_wa   = out_load ? e_reg[AW-1:0] : pop_cmd.addr[AW-1:0];
        run_wd   = out_load ? new_rd_reg : pop_cmd.value;
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (fac_we)
            fac_mem[pop_cmd.addr[AW-1:0]] <= pop_cmd.value;
        if (run_we)
            run_mem[run_wa] <= run_wd;
        if (p3_valid_reg && p3_last_reg)
            new_mem[p3_idx_reg[AW-1:0]] <= sat_val;
        if (issue)
        begin
            fac_rd_reg <= fac_mem[fa[AW-1:0]];
            run_rd_reg <= run_valid_reg[ra[AW-1:0]] ? run_mem[ra[AW-1:0]] : '0;
        end
        if (state_reg == cmp_pkg::ST_EMIT_RD)
            new_rd_reg <= new_mem[e_reg[AW-1:0]];
    end

    // Mark running entries written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_valid_reg <= '0;
        else if (run_we)
            run_valid_reg[run_wa] <= 1'b1;
    end

    // Multiply, scale and accumulate
    assign prod_sh = prod_reg >>> FRACTION_BITS;
    assign term    = {{(AC - 2*EW){prod_sh[2*EW-1]}}, prod_sh};
    assign sat_ovf = !((&acc_reg[AC-1:EW-1]) || !(|acc_reg[AC-1:EW-1]));
    assign sat_val = sat_ovf ? (acc_reg[AC-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}})
                             : acc_reg[EW-1:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(fac_rd_reg) * $signed(run_rd_reg);
        if (p2_valid_reg)
            acc_reg <= p2_first_reg ? term : acc_reg + term;
        p1_first_reg <= (k_reg == '0);
        p1_last_reg  <= (k_reg == n_m1);
        p1_idx_reg   <= ia;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_idx_reg   <= p1_idx_reg;
        p3_last_reg  <= p2_last_reg;
        p3_idx_reg   <= p2_idx_reg;
    end

    // Sequence state and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cmp_pkg::ST_IDLE;
            n_reg          <= cmp_pkg::SIZE_W'(1);
            total_reg      <= CW'(1);
            step_reg       <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            row_base_reg   <= '0;
            rk_reg         <= '0;
            issue_done_reg <= 1'b1;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p3_valid_reg   <= 1'b0;
            e_reg          <= '0;
            oi_reg         <= '0;
            oj_reg         <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (pop && pop_cmd.kind == cmp_pkg::CMD_LOAD_FAC_LAST)
            begin
                n_reg          <= pop_cmd.size;
                total_reg      <= CW'({3'b000, pop_cmd.size} * {3'b000, pop_cmd.size});
                step_reg       <= step_reg + cmp_pkg::STEP_W'(1);
                i_reg          <= '0;
                j_reg          <= '0;
                k_reg          <= '0;
                row_base_reg   <= '0;
                rk_reg         <= '0;
                issue_done_reg <= 1'b0;
            end
            else if (issue)
            begin
                if (k_reg != n_m1)
                begin
                    k_reg  <= k_reg + IW'(1);
                    rk_reg <= rk_reg + CW'(n_reg);
                end
                else
                begin
                    k_reg  <= '0;
                    rk_reg <= '0;
                    if (j_reg != n_m1)
                        j_reg <= j_reg + IW'(1);
                    else
                    begin
                        j_reg        <= '0;
                        i_reg        <= i_reg + IW'(1);
                        row_base_reg <= row_base_reg + CW'(n_reg);
                        if (i_reg == n_m1)
                            issue_done_reg <= 1'b1;
                    end
                end
            end
            if (final_wr)
            begin
                e_reg  <= '0;
                oi_reg <= '0;
                oj_reg <= '0;
            end
            else if (out_load)
            begin
                e_reg <= e_reg + CW'(1);
                if (oj_reg == n_m1)
                begin
                    oj_reg <= '0;
                    oi_reg <= oi_reg + IW'(1);
                end
                else
                    oj_reg <= oj_reg + IW'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg  <= oi_reg;
            out_col_reg  <= oj_reg;
            out_val_reg  <= new_rd_reg;
            out_step_reg <= step_reg;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_step_reg, out_val_reg, out_col_reg, out_row_reg};

`include "cumulative_matrix_product_assert.svh"
    `CMP_ASSERT_SAME(a_emit_after_issue, final_wr && state_reg == cmp_pkg::ST_COMPUTE, issue_done_reg)
    `CMP_ASSERT_SAME(a_wr_in_range, p3_valid_reg && p3_last_reg, p3_idx_reg < total_reg)
    `CMP_ASSERT_NEXT(a_last_to_idle, out_load && emit_last, state_reg == cmp_pkg::ST_IDLE)

endmodule

FILE: hdl/cumulative_matrix_product.sv
// A load item is written into its matrix when it is popped from the command queue; a factor's last item starts
// the multiply-accumulate on one shared 32x32 multiplier,
// then each emitted element is read back, registered for output and copied into the running matrix.
// Throughput: one input transfer per cycle while the 2-entry command queue has room.
// Reset (rst_n, async, low): size 8, running matrix reads as zero, counters cleared.
module cumulative_matrix_product #(
    parameter int MAX_SIZE      = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cmp_pkg::SIZE_W-1:0] cfg_wdata,   // matrix_size
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [cmp_pkg::ELEM_W-1:0] s_tdata,     // element_value
    input  logic                       s_tuser,     // opcode
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // row_index[2:0], column_index[5:3], product_value[37:6], step_number[45:38]
    output logic [cmp_pkg::OUT_W-1:0]  m_tdata,
    output logic                       m_tlast      // last_element
);

    cmp_pkg::cmd_t push_cmd;
    cmp_pkg::cmd_t pop_cmd;
    logic push, pop, full, empty;

    cmp_front #(.MAX_SIZE(MAX_SIZE)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .full(full), .push(push), .push_cmd(push_cmd)
    );

    cmp_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd),
        .pop(pop), .pop_cmd(pop_cmd), .full(full), .empty(empty)
    );

    cmp_back #(.MAX_SIZE(MAX_SIZE), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .empty(empty), .pop_cmd(pop_cmd), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

endmodule
